// ----- rtl/lpg_pkg.sv -----
package lpg_pkg;

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 8;
   localparam int OUT_BITS   = 18;

   // quotient never exceeds d_minor << FRAC_BITS, and d_minor <= d_major
   localparam int QUOT_BITS  = COORD_BITS + FRAC_BITS;
   localparam int DVND_BITS  = 2 * COORD_BITS + FRAC_BITS;
   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int CNT_BITS   = $clog2(QUOT_BITS);
   localparam int SUM_BITS   = (QUOT_BITS + 1 > OUT_BITS) ? QUOT_BITS + 1 : OUT_BITS;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic      mode;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] point_x;
      logic [OUT_BITS-1:0] point_y;
      logic                last_point;
   } rsp_type;

   function automatic coord_type abs_diff(input coord_type a, input coord_type b);
      return (a >= b) ? coord_type'(a - b) : coord_type'(b - a);
   endfunction

endpackage

// ----- rtl/line_point_generator.sv -----
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_data  (lpg_pkg::req_type)
// rsp     | out       | rsp_valid / rsp_ready | rsp_data  (lpg_pkg::rsp_type)
//
// A start item or a step with no line loaded is taken in the idle state and gives nothing.
// A step item's point is computed by the restoring divider at one quotient bit a cycle;
// a single point skips the divider.
// req_ready returns the cycle after the response is taken; one item is in flight.
// A stalled response holds in the output register until rsp_ready.
// Synchronous reset clears the sequencer and drops any loaded line.
module line_point_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lpg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lpg_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type                        state_ff, state_in;
   logic                             active_ff, active_in;
   logic                             x_major_ff, x_major_in;
   lpg_pkg::coord_type               major_now_ff, major_now_in;
   // endpoints are kept already sorted into major and minor axis
   lpg_pkg::coord_type               maj_s_ff, maj_s_in;
   lpg_pkg::coord_type               maj_e_ff, maj_e_in;
   lpg_pkg::coord_type               min_s_ff, min_s_in;
   lpg_pkg::coord_type               min_e_ff, min_e_in;
   lpg_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                             req_fire, rsp_fire;
   logic                             start_x_major;
   lpg_pkg::coord_type               d_major, d_minor, k_steps;
   logic [lpg_pkg::PROD_BITS-1:0]    product;
   logic [lpg_pkg::DVND_BITS-1:0]    dividend;
   logic                             div_start, div_done;
   logic [lpg_pkg::QUOT_BITS-1:0]    div_quot, q_use;
   logic [lpg_pkg::SUM_BITS-1:0]     minor_fx, major_fx;
   logic                             is_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // x is major only when |dy| < |dx|; ties go to y
   assign start_x_major = lpg_pkg::abs_diff(req_data.y_end, req_data.y_start) <
                          lpg_pkg::abs_diff(req_data.x_end, req_data.x_start);

   // one 10x10 product, registered inside the divider as it loads
   always_comb begin
      d_major  = lpg_pkg::abs_diff(maj_e_ff, maj_s_ff);
      d_minor  = lpg_pkg::abs_diff(min_e_ff, min_s_ff);
      k_steps  = lpg_pkg::abs_diff(major_now_ff, maj_s_ff);
      product  = lpg_pkg::PROD_BITS'(d_minor) * lpg_pkg::PROD_BITS'(k_steps);
      dividend = lpg_pkg::DVND_BITS'(product) << lpg_pkg::FRAC_BITS;
   end

   // skip the divider when both endpoints coincide
   assign div_start = (state_ff == ST_LOAD) && (d_major != '0);

   lpg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (d_major),
      .done     (div_done),
      .quotient (div_quot)
   );

   // assemble the point from the quotient, or from zero for a single point
   always_comb begin
      q_use    = (state_ff == ST_DIV) ? div_quot : '0;
      major_fx = lpg_pkg::SUM_BITS'(major_now_ff) << lpg_pkg::FRAC_BITS;
      if (min_e_ff >= min_s_ff) begin
         minor_fx = (lpg_pkg::SUM_BITS'(min_s_ff) << lpg_pkg::FRAC_BITS)
                    + lpg_pkg::SUM_BITS'(q_use);
      end else begin
         minor_fx = (lpg_pkg::SUM_BITS'(min_s_ff) << lpg_pkg::FRAC_BITS)
                    - lpg_pkg::SUM_BITS'(q_use);
      end
      is_last = (major_now_ff == maj_e_ff);
      rsp_in  = rsp_ff;
      if (((state_ff == ST_LOAD) && (d_major == '0)) ||
          ((state_ff == ST_DIV) && div_done)) begin
         rsp_in.point_x    = x_major_ff ? major_fx[lpg_pkg::OUT_BITS-1:0]
                                        : minor_fx[lpg_pkg::OUT_BITS-1:0];
         rsp_in.point_y    = x_major_ff ? minor_fx[lpg_pkg::OUT_BITS-1:0]
                                        : major_fx[lpg_pkg::OUT_BITS-1:0];
         rsp_in.last_point = is_last;
      end
   end

   // sequencer and line state
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      x_major_in   = x_major_ff;
      major_now_in = major_now_ff;
      maj_s_in     = maj_s_ff;
      maj_e_in     = maj_e_ff;
      min_s_in     = min_s_ff;
      min_e_in     = min_e_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.mode == lpg_pkg::MODE_START) begin
                  // load a new line, replacing any active one
                  active_in    = 1'b1;
                  x_major_in   = start_x_major;
                  maj_s_in     = start_x_major ? req_data.x_start : req_data.y_start;
                  maj_e_in     = start_x_major ? req_data.x_end   : req_data.y_end;
                  min_s_in     = start_x_major ? req_data.y_start : req_data.x_start;
                  min_e_in     = start_x_major ? req_data.y_end   : req_data.x_end;
                  major_now_in = start_x_major ? req_data.x_start : req_data.y_start;
               end else if (active_ff) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            state_in = (d_major == '0) ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
               // drop the line after its end point, else walk toward the end
               if (rsp_ff.last_point) begin
                  active_in = 1'b0;
               end else if (maj_e_ff > major_now_ff) begin
                  major_now_in = major_now_ff + 1'b1;
               end else begin
                  major_now_in = major_now_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         x_major_ff   <= 1'b0;
         major_now_ff <= '0;
         maj_s_ff     <= '0;
         maj_e_ff     <= '0;
         min_s_ff     <= '0;
         min_e_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         x_major_ff   <= x_major_in;
         major_now_ff <= major_now_in;
         maj_s_ff     <= maj_s_in;
         maj_e_ff     <= maj_e_in;
         min_s_ff     <= min_s_in;
         min_e_ff     <= min_e_in;
      end
      rsp_ff <= rsp_in;
   end

   // never take a request while a response is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while response pending");

   // divider finishes only while the sequencer waits on it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider done outside divide state");

   // final point retires the line
   a_last_drops: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_data.last_point) |=> !active_ff)
      else $error("line still active after last point");

   // a point other than the last keeps the line and moves the major coordinate
   a_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_data.last_point) |=> (active_ff && !$stable(major_now_ff)))
      else $error("major coordinate did not advance");

   // a step only goes to work on an active line
   a_step_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> active_ff)
      else $error("step processed with no active line");

endmodule

// ----- rtl/lpg_div.sv -----
module lpg_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [lpg_pkg::DVND_BITS-1:0]        dividend,
   input  lpg_pkg::coord_type                   divisor,
   output logic                                 done,
   output logic [lpg_pkg::QUOT_BITS-1:0]        quotient
);

   // restoring divider, one quotient bit a cycle; the top COORD_BITS bits of
   // the dividend are known to be below the divisor
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [lpg_pkg::CNT_BITS-1:0]       cnt_ff, cnt_in;
   lpg_pkg::coord_type                 rem_ff, rem_in;
   logic [lpg_pkg::QUOT_BITS-1:0]      low_ff, low_in;
   logic [lpg_pkg::COORD_BITS:0]       trial;
   logic [lpg_pkg::COORD_BITS:0]       diff;
   logic                               fits;

   always_comb begin
      trial = {rem_ff, low_ff[lpg_pkg::QUOT_BITS-1]};
      diff  = trial - {1'b0, divisor};
      fits  = trial >= {1'b0, divisor};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = lpg_pkg::CNT_BITS'(lpg_pkg::QUOT_BITS - 1);
         rem_in  = dividend[lpg_pkg::DVND_BITS-1 -: lpg_pkg::COORD_BITS];
         low_in  = dividend[lpg_pkg::QUOT_BITS-1:0];
      end else if (busy_ff) begin
         // shift the next dividend bit in, the quotient bit into the bottom
         rem_in = fits ? diff[lpg_pkg::COORD_BITS-1:0] : trial[lpg_pkg::COORD_BITS-1:0];
         low_in = {low_ff[lpg_pkg::QUOT_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

// ----- test/line_point_generator_tb.sv -----
`timescale 1ns / 100ps

module line_point_generator_tb;

   localparam int REQ_BITS        = $bits(lpg_pkg::req_type);
   localparam int COORD_MAX       = (1 << lpg_pkg::COORD_BITS) - 1;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 60;    // comfortably past a step's turnaround
   localparam int WATCHDOG_LIMIT  = 4000;

   // how a directed row gets its expectation
   typedef enum logic [1:0] {
      EXP_MODEL,   // ask the line predictor
      EXP_POINT,   // point typed into the row
      EXP_NONE     // row must give no point
   } row_expect_type;

   typedef struct {
      lpg_pkg::req_type item;
      row_expect_type   how;
      lpg_pkg::rsp_type point;
   } plot_row_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   lpg_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   lpg_pkg::rsp_type rsp_data;

   // points still owed by the block, oldest first
   lpg_pkg::rsp_type expected_points[$];

   int mismatches       = 0;
   int points_checked   = 0;
   int lines_started    = 0;
   int points_predicted = 0;
   int idle_steps       = 0;
   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;
   int hold_off_ticket  = 0;

   // line walker state, mirrors the block's registers
   logic               walk_active  = 1'b0;
   logic               walk_x_major = 1'b0;
   lpg_pkg::coord_type walk_major   = '0;
   lpg_pkg::coord_type walk_x0      = '0;
   lpg_pkg::coord_type walk_y0      = '0;
   lpg_pkg::coord_type walk_x1      = '0;
   lpg_pkg::coord_type walk_y1      = '0;

   line_point_generator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic lpg_pkg::coord_type coord_span(input lpg_pkg::coord_type a,
                                                     input lpg_pkg::coord_type b);
      return (a > b) ? lpg_pkg::coord_type'(a - b) : lpg_pkg::coord_type'(b - a);
   endfunction

   // Walk the loaded line by one item. Return 1 when the item yields a point.
   function automatic bit walk_line(input lpg_pkg::req_type item,
                                    output lpg_pkg::rsp_type point);
      lpg_pkg::coord_type maj0, maj1, min0, min1;
      lpg_pkg::coord_type d_maj, d_min, k;
      longint unsigned    quot, minor_fx, major_fx;
      bit                 at_end;

      point = '0;
      if (item.mode == lpg_pkg::MODE_START) begin
         // latch endpoints, pick the major axis, replace any running line
         walk_x0      = item.x_start;
         walk_y0      = item.y_start;
         walk_x1      = item.x_end;
         walk_y1      = item.y_end;
         walk_x_major = coord_span(walk_y1, walk_y0) < coord_span(walk_x1, walk_x0);
         walk_major   = walk_x_major ? walk_x0 : walk_y0;
         walk_active  = 1'b1;
         return 1'b0;
      end
      if (!walk_active)
         return 1'b0;

      maj0 = walk_x_major ? walk_x0 : walk_y0;
      maj1 = walk_x_major ? walk_x1 : walk_y1;
      min0 = walk_x_major ? walk_y0 : walk_x0;
      min1 = walk_x_major ? walk_y1 : walk_x1;

      d_maj = coord_span(maj1, maj0);
      d_min = coord_span(min1, min0);
      k     = coord_span(walk_major, maj0);

      // single point: no division, offset stays zero
      quot = 0;
      if (d_maj != 0)
         quot = ((64'(d_min) * 64'(k)) << lpg_pkg::FRAC_BITS) / 64'(d_maj);

      minor_fx = 64'(min0) << lpg_pkg::FRAC_BITS;
      if (min1 >= min0)
         minor_fx = minor_fx + quot;
      else
         minor_fx = minor_fx - quot;
      major_fx = 64'(walk_major) << lpg_pkg::FRAC_BITS;
      at_end   = (walk_major == maj1);

      point.point_x    = lpg_pkg::OUT_BITS'(walk_x_major ? major_fx : minor_fx);
      point.point_y    = lpg_pkg::OUT_BITS'(walk_x_major ? minor_fx : major_fx);
      point.last_point = at_end;

      if (at_end)
         walk_active = 1'b0;
      else if (maj1 > walk_major)
         walk_major = walk_major + 1'b1;
      else
         walk_major = walk_major - 1'b1;
      return 1'b1;
   endfunction

   function automatic lpg_pkg::req_type line_req(input logic mode,
                                                 input lpg_pkg::coord_type xs,
                                                 input lpg_pkg::coord_type ys,
                                                 input lpg_pkg::coord_type xe,
                                                 input lpg_pkg::coord_type ye);
      lpg_pkg::req_type r;
      r.mode    = mode;
      r.x_start = xs;
      r.y_start = ys;
      r.x_end   = xe;
      r.y_end   = ye;
      return r;
   endfunction

   // whole-pixel coordinates to a fixed-point point
   function automatic lpg_pkg::rsp_type pixel_point(input int px, input int py,
                                                    input bit fin);
      lpg_pkg::rsp_type p;
      p.point_x    = lpg_pkg::OUT_BITS'(px << lpg_pkg::FRAC_BITS);
      p.point_y    = lpg_pkg::OUT_BITS'(py << lpg_pkg::FRAC_BITS);
      p.last_point = fin;
      return p;
   endfunction

   // favor the borders of the coordinate range
   function automatic lpg_pkg::coord_type pick_coord();
      case ($urandom_range(7))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return lpg_pkg::coord_type'($urandom);
         end
      endcase
   endfunction

   function automatic lpg_pkg::coord_type nudge_coord(input lpg_pkg::coord_type base,
                                                      input int reach);
      int c;
      c = int'(base) + int'($urandom_range(2 * reach)) - reach;
      if (c < 0)
         c = 0;
      if (c > COORD_MAX)
         c = COORD_MAX;
      return lpg_pkg::coord_type'(c);
   endfunction

   // Offer one item, hold it until the block takes it, then book its expectation.
   // Call at a rising edge; leave valid high so back-to-back items never glitch it.
   task automatic offer_item(input lpg_pkg::req_type item, input row_expect_type how,
                             input lpg_pkg::rsp_type typed_point);
      lpg_pkg::rsp_type predicted;
      bit               yields;

      // idle the sender a random number of cycles
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);

      yields = walk_line(item, predicted);
      if (item.mode == lpg_pkg::MODE_START)
         lines_started++;
      else if (yields)
         points_predicted++;
      else
         idle_steps++;

      case (how)
         EXP_MODEL: begin
            if (yields)
               expected_points.push_back(predicted);
         end
         EXP_POINT: begin
            expected_points.push_back(typed_point);
         end
         default: begin
         end
      endcase
   endtask

   // Drop valid and pause the sender until every owed point has come back.
   task automatic wait_all_points();
      req_valid <= 1'b0;
      while (expected_points.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Result side: check each taken point, then choose ready for the next edge.
   initial begin : point_checker
      lpg_pkg::rsp_type want;
      int               ticket_seen;
      int               hold_left;

      ticket_seen = 0;
      hold_left   = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected point x=%0d y=%0d last=%0d", $time,
                        rsp_data.point_x, rsp_data.point_y, rsp_data.last_point);
               mismatches++;
            end else begin
               want = expected_points.pop_front();
               points_checked++;
               if (rsp_data.point_x !== want.point_x) begin
                  $display("%0t: point_x expected %0d, got %0d", $time,
                           want.point_x, rsp_data.point_x);
                  mismatches++;
               end
               if (rsp_data.point_y !== want.point_y) begin
                  $display("%0t: point_y expected %0d, got %0d", $time,
                           want.point_y, rsp_data.point_y);
                  mismatches++;
               end
               if (rsp_data.last_point !== want.last_point) begin
                  $display("%0t: last_point expected %0d, got %0d", $time,
                           want.last_point, rsp_data.last_point);
                  mismatches++;
               end
            end
         end

         // a new ticket starts a long hold-off, counted down here
         if (hold_off_ticket != ticket_seen) begin
            ticket_seen = hold_off_ticket;
            hold_left   = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // End the run when neither channel moves an item for too long.
   initial begin : watchdog
      int quiet;

      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[line_point_generator] ERROR");
      $finish;
   end

   initial begin : stimulus
      plot_row_type     directed_rows[$];
      lpg_pkg::req_type start_req;
      lpg_pkg::req_type step_req;
      int               reach;
      int               span;
      int               n_steps;
      bit               noise;

      // Directed rows: empty steps, single points at both corners, a vertical
      // line, a backward horizontal line at the edge, a falling diagonal, a
      // shallow line left to the walker, and a line cut short by a new start.
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, '1, '1, '1, '1),
                                EXP_NONE, '0});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_START, 0, 0, 0, 0), EXP_NONE, '0});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(0, 0, 1)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_NONE, '0});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_START, 1023, 1023, 1023, 1023),
                                EXP_NONE, '0});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, '1, 0, '1), EXP_POINT,
                                pixel_point(1023, 1023, 1)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_START, 5, 3, 5, 5), EXP_NONE, '0});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(5, 3, 0)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(5, 4, 0)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(5, 5, 1)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_START, 1023, 0, 1021, 0),
                                EXP_NONE, '0});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(1023, 0, 0)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(1022, 0, 0)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(1021, 0, 1)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_START, 0, 1023, 2, 1021),
                                EXP_NONE, '0});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(0, 1023, 0)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(1, 1022, 0)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(2, 1021, 1)});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_START, 0, 0, 3, 1), EXP_NONE, '0});
      repeat (4)
         directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0),
                                   EXP_MODEL, '0});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_START, 0, 0, 1023, 1023),
                                EXP_NONE, '0});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(0, 0, 0)});
      // replace a line that is still running
      directed_rows.push_back('{line_req(lpg_pkg::MODE_START, 1023, 0, 0, 1023),
                                EXP_NONE, '0});
      directed_rows.push_back('{line_req(lpg_pkg::MODE_STEP, 0, 0, 0, 0), EXP_POINT,
                                pixel_point(1023, 0, 0)});

      // hold reset, then release it
      repeat (3)
         @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_item(directed_rows[i].item, directed_rows[i].how, directed_rows[i].point);
      wait_all_points();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  =  0;
               recv_stall_pct <= 0;
               // stall the receiver for a long stretch while items keep coming
               hold_off_ticket <= hold_off_ticket + 1;
            end
            1: begin
               send_idle_pct  = 57;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct  =  0;
               recv_stall_pct <= 57;
            end
            default: begin
               send_idle_pct  = 21;
               recv_stall_pct <= 21;
            end
         endcase

         // Mostly whole short lines with random content; now and then a long
         // line, an overrun past the end, a cut-short line, or a wild start.
         while (lines_started + points_predicted < (phase + 1) * ITEMS_PER_PHASE) begin
            noise = ($urandom_range(7) == 0);
            reach = ($urandom_range(19) == 0) ? 60 : 6;
            start_req.mode    = lpg_pkg::MODE_START;
            start_req.x_start = pick_coord();
            start_req.y_start = pick_coord();
            if (noise) begin
               start_req.x_end = pick_coord();
               start_req.y_end = pick_coord();
            end else begin
               start_req.x_end = nudge_coord(start_req.x_start, reach);
               start_req.y_end = nudge_coord(start_req.y_start, reach);
            end
            offer_item(start_req, EXP_MODEL, '0);

            span = int'(coord_span(start_req.x_end, start_req.x_start));
            if (int'(coord_span(start_req.y_end, start_req.y_start)) > span)
               span = int'(coord_span(start_req.y_end, start_req.y_start));
            n_steps = span + 1;
            if (noise) begin
               n_steps = int'($urandom_range(4));
            end else begin
               case ($urandom_range(9))
                  0: begin
                     n_steps = n_steps + int'($urandom_range(2, 1));
                  end
                  1: begin
                     n_steps = int'($urandom_range(span));
                  end
                  default: begin
                  end
               endcase
            end

            // step fields carry random junk that the block must ignore
            repeat (n_steps) begin
               step_req      = REQ_BITS'({$urandom, $urandom});
               step_req.mode = lpg_pkg::MODE_STEP;
               offer_item(step_req, EXP_MODEL, '0);
            end
         end
         wait_all_points();
      end

      // let any stray point show up before judging
      repeat (SETTLE_CYCLES)
         @(posedge clock);

      $display("covered %0d lines and %0d checked points over four idle/stall phases,",
               lines_started, points_checked);
      $display("with %0d steps on no line and a %0d-cycle receiver hold-off",
               idle_steps, HOLD_OFF_CYCLES);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("[line_point_generator] OK");
      end else begin
         $display("%0d mismatches, %0d points never delivered", mismatches,
                  expected_points.size());
         $display("[line_point_generator] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/lpg_pkg.sv
rtl/lpg_div.sv
rtl/line_point_generator.sv
test/line_point_generator_tb.sv
